[design/mouse_click_tracker_macros.svh]
// Assertion macros for the mouse click tracker.
`ifndef MOUSE_CLICK_TRACKER_MACROS_SVH
`define MOUSE_CLICK_TRACKER_MACROS_SVH

`ifndef ASSERT_OFF

`define MCT_ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("mouse_click_tracker: forbidden condition seen");

`define MCT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mouse_click_tracker: implication failed");

`else

`define MCT_ASSERT_NEVER(label, clk, rst_n, cond)

`define MCT_ASSERT_IMPL(label, clk, rst_n, ante, cons)

`endif

`endif

[design/mct_pkg.sv]
// Shared types and constants of the mouse click tracker.
package mct_pkg;

  localparam int TimeBits = 48;
  localparam int WheelDelta = 120;

  localparam logic [15:0] DragMask = 16'h1F00;
  localparam logic [15:0] CountMax = 16'hFFFF;
  localparam logic signed [15:0] Int16Max = 16'sh7FFF;
  localparam logic signed [15:0] Int16Min = 16'sh8000;
  localparam logic [31:0] WindowReset = 32'd200;

  typedef enum logic [1:0] {
    CMD_PRESS   = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_MOVE    = 2'd2,
    CMD_WHEEL   = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    KIND_PRESSED  = 3'd0,
    KIND_RELEASED = 3'd1,
    KIND_CLICKED  = 3'd2,
    KIND_MOVED    = 3'd3,
    KIND_DRAGGED  = 3'd4,
    KIND_WHEEL    = 3'd5
  } kind_e;

  typedef struct packed {
    cmd_e               cmd;
    logic [47:0]        stamp;
    logic [7:0]         button_id;
    logic [15:0]        modifiers;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] wheel_steps;
    logic [7:0]         wheel_dir;
    logic               release_taken;
  } req_t;

  typedef struct packed {
    kind_e              kind;
    logic [47:0]        out_stamp;
    logic [7:0]         out_button;
    logic [15:0]        clicks;
    logic [15:0]        out_modifiers;
    logic signed [15:0] out_x;
    logic signed [15:0] out_y;
    logic signed [15:0] rotation;
    logic [7:0]         out_dir;
    logic               last;
  } res_t;

  typedef struct packed {
    logic [15:0]         count;
    logic [TimeBits-1:0] press_time;
    logic [7:0]          button;
    logic                drag;
  } track_t;

endpackage

[design/mct_in_if.sv]
// Request channel of the mouse click tracker.
interface mct_in_if import mct_pkg::*;;
  logic valid;
  logic ready;
  req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[design/mct_out_if.sv]
// Result channel of the mouse click tracker.
interface mct_out_if import mct_pkg::*;;
  logic valid;
  logic ready;
  res_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[design/mct_cfg_if.sv]
// Click window write channel of the mouse click tracker.
interface mct_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[design/mct_classify.sv]
// Event classification and click tracking update for one request.
module mct_classify import mct_pkg::*; (
  input  req_t        req_i,
  input  track_t      track_i,
  input  logic [31:0] window_i,
  output track_t      track_o,
  output res_t        res_o,
  output logic        click_o
);

  logic [TimeBits-1:0] diff;
  logic                outside;
  logic                same_btn;
  logic signed [23:0]  prod;
  logic signed [15:0]  rot;

  assign diff     = req_i.stamp[TimeBits-1:0] - track_i.press_time;
  assign outside  = diff > TimeBits'(window_i);
  assign same_btn = req_i.button_id == track_i.button;
  assign prod     = 24'(req_i.wheel_steps) * 24'(WheelDelta);

  always_comb begin
    if (prod > 24'(Int16Max)) begin
      rot = Int16Max;
    end else if (prod < 24'(Int16Min)) begin
      rot = Int16Min;
    end else begin
      rot = prod[15:0];
    end
  end

  always_comb begin
    track_o = track_i;
    click_o = 1'b0;
    res_o.kind          = KIND_PRESSED;
    res_o.out_stamp     = req_i.stamp;
    res_o.out_button    = req_i.button_id;
    res_o.clicks        = track_i.count;
    res_o.out_modifiers = req_i.modifiers;
    res_o.out_x         = req_i.pos_x;
    res_o.out_y         = req_i.pos_y;
    res_o.rotation      = '0;
    res_o.out_dir       = '0;
    res_o.last          = 1'b1;
    case (req_i.cmd)
      CMD_PRESS: begin
        if (same_btn && !outside) begin
          if (track_i.count != CountMax) begin
            track_o.count = track_i.count + 16'd1;
          end
        end else begin
          track_o.count  = 16'd1;
          track_o.button = req_i.button_id;
        end
        track_o.press_time = req_i.stamp[TimeBits-1:0];
        track_o.drag       = 1'b0;
        res_o.clicks       = track_o.count;
      end
      CMD_RELEASE: begin
        click_o    = !req_i.release_taken && !track_i.drag;
        res_o.kind = KIND_RELEASED;
        res_o.last = !click_o;
        if (same_btn && outside) begin
          track_o.count = '0;
        end
      end
      CMD_MOVE: begin
        if (track_i.count != '0 && outside) begin
          track_o.count = '0;
        end
        res_o.out_button = '0;
        res_o.clicks     = track_o.count;
        if ((req_i.modifiers & DragMask) != '0) begin
          res_o.kind   = KIND_DRAGGED;
          track_o.drag = 1'b1;
        end else begin
          res_o.kind = KIND_MOVED;
        end
      end
      default: begin
        track_o.count    = '0;
        track_o.button   = '0;
        res_o.kind       = KIND_WHEEL;
        res_o.out_button = '0;
        res_o.clicks     = '0;
        res_o.rotation   = rot;
        res_o.out_dir    = req_i.wheel_dir;
      end
    endcase
  end

endmodule

[design/mouse_click_tracker.sv]
// Top level of the mouse click tracker: state, result register and handshakes.
//
//   channel   dir   payload                    accepted when
//   in_i      in    req_t (mouse event)        in_i.valid && in_i.ready
//   out_o     out   res_t (classified event)   out_o.valid && out_o.ready
//   cfg_i     in    click window, 32 bit       cfg_i.valid && cfg_i.ready
//
// One request per cycle; each leaves its results in the result register
// the cycle after it is taken. A release that also clicks holds the output
// for a second result, and no new request is taken until that release
// result has drained. Reset clears the click state and sets the window to
// 200. The input stalls while the result register is full and not being
// drained, and while a trailing click waits behind its release.
`include "mouse_click_tracker_macros.svh"

module mouse_click_tracker import mct_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  mct_in_if.sink    in_i,
  mct_out_if.source out_o,
  mct_cfg_if.sink   cfg_i
);

  logic [31:0] window_q;
  track_t      track_q;
  track_t      track_d;
  res_t        res_q;
  res_t        res_d;
  logic        out_valid_q;
  logic        pend_q;
  logic        click_d;
  logic        in_fire;
  logic        out_fire;

  mct_classify u_classify (
    .req_i    (in_i.data),
    .track_i  (track_q),
    .window_i (window_q),
    .track_o  (track_d),
    .res_o    (res_d),
    .click_o  (click_d)
  );

  assign in_i.ready  = !pend_q && (!out_valid_q || out_o.ready);
  assign cfg_i.ready = 1'b1;
  assign in_fire     = in_i.valid && in_i.ready;
  assign out_fire    = out_valid_q && out_o.ready;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= WindowReset;
    end else if (cfg_i.valid) begin
      window_q <= cfg_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      track_q     <= '0;
      out_valid_q <= 1'b0;
      pend_q      <= 1'b0;
    end else if (in_fire) begin
      track_q     <= track_d;
      out_valid_q <= 1'b1;
      pend_q      <= click_d;
    end else if (out_fire) begin
      // advance to the trailing click, or drain
      if (pend_q) begin
        pend_q <= 1'b0;
      end else begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      res_q <= res_d;
    end else if (out_fire && pend_q) begin
      res_q.kind <= KIND_CLICKED;
      res_q.last <= 1'b1;
    end
  end

  `MCT_ASSERT_NEVER(a_pend_has_valid, clk_i, rst_ni, pend_q && !out_valid_q)
  `MCT_ASSERT_IMPL(a_pend_is_release, clk_i, rst_ni, pend_q,
                   res_q.kind == KIND_RELEASED && !res_q.last)
  `MCT_ASSERT_IMPL(a_pend_blocks_in, clk_i, rst_ni, pend_q, !in_i.ready)
  `MCT_ASSERT_IMPL(a_click_follows, clk_i, rst_ni, out_fire && pend_q,
                   ##1 (out_valid_q && res_q.kind == KIND_CLICKED && res_q.last))

endmodule
